### rtl/core/iee_pkg.sv
`timescale 1ns / 1ps

package iee_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned OUT_VALUE_BITS = 64;
  localparam int unsigned CHAR_BITS      = 8;

  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_SYNTAX  = 2'd1,
    ERR_DIVZERO = 2'd2,
    ERR_RANGE   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0,
    PH_MINUS  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_AFTER  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_MUL  = 2'd1,
    MUL_DIV  = 2'd2
  } mul_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FIN  = 2'd1,
    ST_MD   = 2'd2,
    ST_POST = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0,
    MD_RUN  = 2'd1,
    MD_FIX  = 2'd2
  } md_state_e;

  typedef enum logic {
    MD_OP_MUL = 1'b0,
    MD_OP_DIV = 1'b1
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
    logic   b_neg;
  } md_req_t;

endpackage

### rtl/core/iee_muldiv.sv
`timescale 1ns / 1ps

module iee_muldiv import iee_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  md_req_t               req_i,
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] result_o
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_BITS - 1);

  md_state_e   state_q, state_d;
  md_op_e      op_q, op_d;
  logic        neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] opnd_q, opnd_d;
  logic [W-1:0] shr_q, shr_d;

  logic [W-1:0] add_a, add_b, res_mag;
  logic         add_cin;
  logic [W:0]   add_sum;

  always_comb begin
    if (op_q == MD_OP_DIV) begin
      add_a   = {acc_q[W-2:0], shr_q[W-1]};
      add_b   = ~opnd_q;
      add_cin = 1'b1;
    end else begin
      add_a   = acc_q;
      add_b   = shr_q[0] ? opnd_q : '0;
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_cin};
  end

  assign res_mag  = (op_q == MD_OP_MUL) ? acc_q : shr_q;
  assign result_o = neg_q ? (W'(0) - res_mag) : res_mag;
  assign done_o   = (state_q == MD_FIX);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    opnd_d  = opnd_q;
    shr_d   = shr_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          state_d = MD_RUN;
          op_d    = req_i.op;
          cnt_d   = '0;
          acc_d   = '0;
          if (req_i.op == MD_OP_DIV) begin
            opnd_d = b_i;
            shr_d  = a_i[W-1] ? (W'(0) - a_i) : a_i;
            neg_d  = a_i[W-1] ^ req_i.b_neg;
          end else begin
            opnd_d = a_i;
            shr_d  = b_i;
            neg_d  = req_i.b_neg;
          end
        end
      end
      MD_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == MD_OP_DIV) begin
          // restoring step, quotient bit shifts in from the right
          if (add_sum[W]) begin
            acc_d = add_sum[W-1:0];
            shr_d = {shr_q[W-2:0], 1'b1};
          end else begin
            acc_d = add_a;
            shr_d = {shr_q[W-2:0], 1'b0};
          end
        end else begin
          acc_d  = add_sum[W-1:0];
          opnd_d = {opnd_q[W-2:0], 1'b0};
          shr_d  = {1'b0, shr_q[W-1:1]};
        end
        if (cnt_q == CNT_LAST) begin
          state_d = MD_FIX;
        end
      end
      MD_FIX: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      op_q    <= MD_OP_MUL;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    shr_q  <= shr_d;
  end

endmodule

### rtl/core/integer_expression_evaluator.sv
`timescale 1ns / 1ps

// Evaluates an integer infix expression (+ - * /, usual precedence, left to right,
// optional leading minus on literals, spaces skipped) fed one ASCII character per
// input word, with tlast on the final character; that character yields one output
// word with the value (sign-extended to 64 bits, wrapping at VALUE_BITS) and an
// error kind in tuser. A character that ends a literal keeps the block busy in its
// finish state and then, unless a divisor is zero, its post state; one that closes
// a * or / term also waits between them on the shared shift and add/subtract unit,
// which retires one multiplier or quotient bit per cycle. The input is not ready
// while that work runs, nor while a finished result waits and is not being taken.
module integer_expression_evaluator import iee_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [CHAR_BITS-1:0]      s_axis_tdata,  // in_char
  input  logic                      s_axis_tlast,  // in_last
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_VALUE_BITS-1:0] m_axis_tdata,  // value
  output logic [1:0]                m_axis_tuser   // error_kind
);

  localparam int unsigned W = VALUE_BITS;
  localparam logic [W-1:0] VSIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] VONE  = W'(1);

  state_e  state_q, state_d;
  logic [W-1:0] sum_q, sum_d;
  logic [W-1:0] prod_q, prod_d;
  logic    pend_sub_q, pend_sub_d;
  mul_e    pend_mul_q, pend_mul_d;
  logic [W-1:0] lit_q, lit_d;
  logic    neg_q, neg_d;
  phase_e  phase_q, phase_d;
  err_e    err_q, err_d;
  op_e     post_op_q, post_op_d;
  logic    post_has_op_q, post_has_op_d;
  logic    post_last_q, post_last_d;
  logic    out_valid_q, out_valid_d;
  logic [OUT_VALUE_BITS-1:0] out_value_q, out_value_d;
  err_e    out_err_q, out_err_d;

  logic         in_fire;
  logic         is_digit, is_space, is_oper;
  op_e          char_op;
  logic [CHAR_BITS-1:0] digit_raw;
  logic [W+3:0] lit10, limit;
  logic         range_err;
  logic [W-1:0] fold_sum, v_lit;

  err_e    err_t;
  phase_e  phase_t;
  logic    need_fin, apply_en, emit_en, emit_ok;
  op_e     apply_op;
  err_e    emit_err;

  md_req_t      md_req;
  logic         md_done;
  logic [W-1:0] md_result;

  iee_muldiv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (prod_q),
    .b_i      (lit_q),
    .done_o   (md_done),
    .result_o (md_result)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_err_q;

  assign is_digit  = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign is_space  = (s_axis_tdata == CH_SPACE);
  assign is_oper   = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS) ||
                     (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH);
  assign digit_raw = s_axis_tdata - CH_ZERO;

  always_comb begin
    if (s_axis_tdata == CH_PLUS) begin
      char_op = OP_ADD;
    end else if (s_axis_tdata == CH_MINUS) begin
      char_op = OP_SUB;
    end else if (s_axis_tdata == CH_STAR) begin
      char_op = OP_MUL;
    end else begin
      char_op = OP_DIV;
    end
  end

  // literal * 10 + digit, checked against the signed range
  assign lit10     = ({4'b0000, lit_q} << 3) + ({4'b0000, lit_q} << 1) +
                     {{W{1'b0}}, digit_raw[3:0]};
  assign limit     = {4'b0000, (neg_q ? VSIGN : (VSIGN - VONE))};
  assign range_err = (lit10 > limit);

  assign fold_sum = pend_sub_q ? (sum_q - prod_q) : (sum_q + prod_q);
  assign v_lit    = neg_q ? (W'(0) - lit_q) : lit_q;

  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    prod_d        = prod_q;
    pend_sub_d    = pend_sub_q;
    pend_mul_d    = pend_mul_q;
    lit_d         = lit_q;
    neg_d         = neg_q;
    phase_d       = phase_q;
    err_d         = err_q;
    post_op_d     = post_op_q;
    post_has_op_d = post_has_op_q;
    post_last_d   = post_last_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_value_d   = out_value_q;
    out_err_d     = out_err_q;
    md_req        = '{start: 1'b0, op: MD_OP_MUL, b_neg: neg_q};
    err_t         = ERR_OK;
    phase_t       = phase_q;
    need_fin      = 1'b0;
    apply_en      = 1'b0;
    apply_op      = char_op;
    emit_en       = 1'b0;
    emit_ok       = 1'b0;
    emit_err      = ERR_OK;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (err_q != ERR_OK) begin
            if (s_axis_tlast) begin
              emit_en  = 1'b1;
              emit_err = err_q;
            end
          end else begin
            case (phase_q)
              PH_EXPECT: begin
                if (s_axis_tdata == CH_MINUS) begin
                  neg_d   = 1'b1;
                  phase_t = PH_MINUS;
                end else if (is_digit) begin
                  if (range_err) begin
                    err_t = ERR_RANGE;
                  end else begin
                    lit_d   = lit10[W-1:0];
                    phase_t = PH_DIGITS;
                  end
                end else if (!is_space) begin
                  err_t = ERR_SYNTAX;
                end
              end
              PH_MINUS: begin
                if (is_digit) begin
                  if (range_err) begin
                    err_t = ERR_RANGE;
                  end else begin
                    lit_d   = lit10[W-1:0];
                    phase_t = PH_DIGITS;
                  end
                end else begin
                  err_t = ERR_SYNTAX;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  if (range_err) begin
                    err_t = ERR_RANGE;
                  end else begin
                    lit_d = lit10[W-1:0];
                  end
                end else if (is_space || is_oper) begin
                  need_fin = 1'b1;
                end else begin
                  err_t = ERR_SYNTAX;
                end
              end
              PH_AFTER: begin
                if (is_oper) begin
                  apply_en = 1'b1;
                end else if (!is_space) begin
                  err_t = ERR_SYNTAX;
                end
              end
              default: begin
                err_t = ERR_SYNTAX;
              end
            endcase

            if (err_t != ERR_OK) begin
              err_d = err_t;
              if (s_axis_tlast) begin
                emit_en  = 1'b1;
                emit_err = err_t;
              end
            end else if (need_fin || (s_axis_tlast && (phase_t == PH_DIGITS))) begin
              state_d       = ST_FIN;
              phase_d       = phase_t;
              post_has_op_d = need_fin && is_oper;
              post_op_d     = char_op;
              post_last_d   = s_axis_tlast;
            end else if (s_axis_tlast) begin
              emit_en = 1'b1;
              if ((phase_t == PH_AFTER) && !apply_en) begin
                emit_ok = 1'b1;
              end else begin
                emit_err = ERR_SYNTAX;
              end
            end else begin
              phase_d = phase_t;
            end
          end
        end
      end
      ST_FIN: begin
        lit_d   = '0;
        neg_d   = 1'b0;
        phase_d = PH_AFTER;
        case (pend_mul_q)
          MUL_NONE: begin
            prod_d  = v_lit;
            state_d = ST_POST;
          end
          MUL_MUL: begin
            md_req.start = 1'b1;
            md_req.op    = MD_OP_MUL;
            state_d      = ST_MD;
          end
          MUL_DIV: begin
            if (lit_q == '0) begin
              err_d   = ERR_DIVZERO;
              state_d = ST_IDLE;
              if (post_last_q) begin
                emit_en  = 1'b1;
                emit_err = ERR_DIVZERO;
              end
            end else begin
              md_req.start = 1'b1;
              md_req.op    = MD_OP_DIV;
              state_d      = ST_MD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MD: begin
        if (md_done) begin
          prod_d  = md_result;
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_IDLE;
        if (post_has_op_q) begin
          apply_en = 1'b1;
          apply_op = post_op_q;
        end
        if (post_last_q) begin
          emit_en = 1'b1;
          if (post_has_op_q) begin
            emit_err = ERR_SYNTAX;
          end else begin
            emit_ok = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (apply_en) begin
      phase_d = PH_EXPECT;
      case (apply_op)
        OP_ADD, OP_SUB: begin
          sum_d      = fold_sum;
          pend_sub_d = (apply_op == OP_SUB);
          pend_mul_d = MUL_NONE;
        end
        OP_MUL: begin
          pend_mul_d = MUL_MUL;
        end
        default: begin
          pend_mul_d = MUL_DIV;
        end
      endcase
    end

    // final character: deliver the word and start a fresh expression
    if (emit_en) begin
      out_valid_d = 1'b1;
      out_value_d = emit_ok ? OUT_VALUE_BITS'(signed'(fold_sum)) : '0;
      out_err_d   = emit_ok ? ERR_OK : emit_err;
      sum_d       = '0;
      prod_d      = '0;
      pend_sub_d  = 1'b0;
      pend_mul_d  = MUL_NONE;
      lit_d       = '0;
      neg_d       = 1'b0;
      phase_d     = PH_EXPECT;
      err_d       = ERR_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sum_q         <= '0;
      prod_q        <= '0;
      pend_sub_q    <= 1'b0;
      pend_mul_q    <= MUL_NONE;
      lit_q         <= '0;
      neg_q         <= 1'b0;
      phase_q       <= PH_EXPECT;
      err_q         <= ERR_OK;
      post_has_op_q <= 1'b0;
      post_last_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sum_q         <= sum_d;
      prod_q        <= prod_d;
      pend_sub_q    <= pend_sub_d;
      pend_mul_q    <= pend_mul_d;
      lit_q         <= lit_d;
      neg_q         <= neg_d;
      phase_q       <= phase_d;
      err_q         <= err_d;
      post_has_op_q <= post_has_op_d;
      post_last_q   <= post_last_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    post_op_q   <= post_op_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

endmodule

### test/expr_result_checker.sv
`timescale 1ns / 1ps

module expr_result_checker import iee_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic                      s_ready_i,
  input  logic [CHAR_BITS-1:0]      s_char_i,
  input  logic                      s_last_i,
  input  logic                      m_valid_i,
  input  logic                      m_ready_i,
  input  logic [OUT_VALUE_BITS-1:0] m_value_i,
  input  logic [1:0]                m_err_i,
  output int unsigned               pending_o,
  output int unsigned               fails_o
);

  localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] VSIGN = 64'd1 << (VALUE_BITS - 1);
  localparam int unsigned REPORT_CAP = 100;

  typedef struct packed {
    logic [63:0] value;
    err_e        err;
  } expr_result_t;

  logic [63:0] sum_q;
  logic [63:0] prod_q;
  logic [63:0] lit_q;
  logic        sub_pend;
  logic        lit_neg;
  mul_e        mul_pend;
  phase_e      phase;
  err_e        err_q;

  expr_result_t due_q[$];
  int unsigned  fails = 0;
  int unsigned  pending = 0;

  assign pending_o = pending;
  assign fails_o   = fails;

  function automatic logic [63:0] sx(input logic [63:0] x);
    logic [63:0] r;
    r = x & VMASK;
    if ((r & VSIGN) != 64'd0) r = r | ~VMASK;
    return r;
  endfunction

  function automatic logic [63:0] quot(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] sa, sb, ma, mb, q;
    logic        na, nb;
    sa = sx(a);
    sb = sx(b);
    na = sa[63];
    nb = sb[63];
    ma = na ? (64'd0 - sa) : sa;
    mb = nb ? (64'd0 - sb) : sb;
    q  = ma / mb;
    if (na != nb) q = 64'd0 - q;
    return q & VMASK;
  endfunction

  task automatic clear_state();
    sum_q    = '0;
    prod_q   = '0;
    lit_q    = '0;
    sub_pend = 1'b0;
    lit_neg  = 1'b0;
    mul_pend = MUL_NONE;
    phase    = PH_EXPECT;
    err_q    = ERR_OK;
  endtask

  task automatic close_literal();
    logic [63:0] v;
    v = (lit_neg ? (64'd0 - lit_q) : lit_q) & VMASK;
    if (mul_pend == MUL_DIV && v == 64'd0) begin
      err_q = ERR_DIVZERO;
    end else begin
      if (mul_pend == MUL_MUL) begin
        prod_q = (prod_q * v) & VMASK;
      end else if (mul_pend == MUL_DIV) begin
        prod_q = quot(prod_q, v);
      end else begin
        prod_q = v;
      end
      lit_q   = '0;
      lit_neg = 1'b0;
    end
  endtask

  task automatic fold_term();
    sum_q = (sub_pend ? (sum_q - prod_q) : (sum_q + prod_q)) & VMASK;
  endtask

  task automatic apply_op(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) begin
      fold_term();
      sub_pend = (c == CH_MINUS);
      mul_pend = MUL_NONE;
    end else begin
      mul_pend = (c == CH_STAR) ? MUL_MUL : MUL_DIV;
    end
    phase = PH_EXPECT;
  endtask

  task automatic push_digit(input logic [7:0] c);
    logic [63:0] dv, limit;
    dv    = 64'(c - CH_ZERO);
    limit = lit_neg ? VSIGN : (VSIGN - 64'd1);
    if (lit_q > (limit - dv) / 64'd10) begin
      err_q = ERR_RANGE;
    end else begin
      lit_q = lit_q * 64'd10 + dv;
      phase = PH_DIGITS;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic is_digit, is_op;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    is_op    = (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH);
    case (phase)
      PH_EXPECT: begin
        if (c == CH_SPACE) begin
        end else if (c == CH_MINUS) begin
          lit_neg = 1'b1;
          phase   = PH_MINUS;
        end else if (is_digit) begin
          push_digit(c);
        end else begin
          err_q = ERR_SYNTAX;
        end
      end
      PH_MINUS: begin
        if (is_digit) push_digit(c);
        else err_q = ERR_SYNTAX;
      end
      PH_DIGITS: begin
        if (is_digit) begin
          push_digit(c);
        end else if (c == CH_SPACE) begin
          close_literal();
          phase = PH_AFTER;
        end else if (is_op) begin
          close_literal();
          if (err_q == ERR_OK) apply_op(c);
        end else begin
          err_q = ERR_SYNTAX;
        end
      end
      default: begin
        if (c == CH_SPACE) begin
        end else if (is_op) begin
          apply_op(c);
        end else begin
          err_q = ERR_SYNTAX;
        end
      end
    endcase
  endtask

  task automatic eat_char(input logic [7:0] c, input logic last);
    expr_result_t r;
    if (err_q == ERR_OK) take_char(c);
    if (last) begin
      if (err_q == ERR_OK) begin
        if (phase == PH_DIGITS) begin
          close_literal();
          phase = PH_AFTER;
        end else if (phase != PH_AFTER) begin
          err_q = ERR_SYNTAX;
        end
      end
      r.value = '0;
      if (err_q == ERR_OK) begin
        fold_term();
        r.value = sx(sum_q);
      end
      r.err = err_q;
      due_q.push_back(r);
      clear_state();
    end
  endtask

  task automatic check_result();
    expr_result_t r;
    if (due_q.size() == 0) begin
      fails++;
      if (fails <= REPORT_CAP)
        $display("%0t: unexpected word, expected none, actual value %h err %0d",
                 $time, m_value_i, m_err_i);
    end else begin
      r = due_q.pop_front();
      if (m_value_i !== r.value) begin
        fails++;
        if (fails <= REPORT_CAP)
          $display("%0t: value mismatch, expected %h actual %h", $time, r.value, m_value_i);
      end
      if (m_err_i !== r.err) begin
        fails++;
        if (fails <= REPORT_CAP)
          $display("%0t: err mismatch, expected %0d actual %0d", $time, r.err, m_err_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      due_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) eat_char(s_char_i, s_last_i);
      if (m_valid_i && m_ready_i) check_result();
    end
    pending = due_q.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import iee_pkg::*;

  localparam int unsigned VB          = VALUE_BITS_DEF;
  localparam int unsigned CHAR_BUDGET = 1600;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN       = 80;
  localparam logic [63:0] VMIN_MAG    = 64'd1 << (VB - 1);
  localparam logic [63:0] VMAX        = VMIN_MAG - 64'd1;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_char  = '0;
  logic        s_last  = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_value;
  logic [1:0]  m_err;

  int unsigned pending;
  int unsigned fails;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  bit          steady = 1'b0;
  byte unsigned text_q[$];

  integer_expression_evaluator #(
    .VALUE_BITS(VB)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_char),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_value),
    .m_axis_tuser  (m_err)
  );

  expr_result_checker #(
    .VALUE_BITS(VB)
  ) result_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_valid_i (s_valid),
    .s_ready_i (s_ready),
    .s_char_i  (s_char),
    .s_last_i  (s_last),
    .m_valid_i (m_valid),
    .m_ready_i (m_ready),
    .m_value_i (m_value),
    .m_err_i   (m_err),
    .pending_o (pending),
    .fails_o   (fails)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // no word moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 14)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 2);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_char  <= c;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s.getc(i));
  endtask

  task automatic put_spaces();
    if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic put_num(input bit neg, input logic [63:0] mag);
    byte unsigned digits[$];
    if (neg) text_q.push_back(CH_MINUS);
    do begin
      digits.push_front(8'(CH_ZERO + (mag % 64'd10)));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    foreach (digits[i]) text_q.push_back(digits[i]);
  endtask

  task automatic put_literal();
    logic [63:0] mag;
    int unsigned r;
    bit          neg;
    r   = $urandom_range(0, 99);
    neg = ($urandom_range(0, 3) == 0);
    mag = '0;
    if (r < 50) begin
      mag = 64'($urandom_range(0, 9));
    end else if (r < 70) begin
      mag = 64'($urandom_range(0, 999));
    end else if (r < 82) begin
      mag = {$urandom, $urandom} >> $urandom_range(0, 63);
    end else if (r < 90) begin
      case ($urandom_range(0, 4))
        0:       mag = VMAX;
        1:       mag = VMIN_MAG;
        2:       mag = VMIN_MAG + 64'd1;
        3:       mag = VMAX - 64'd1;
        default: mag = '1;
      endcase
    end
    // over-long digit runs, leading zeros allowed
    if (r >= 95) begin
      if (neg) text_q.push_back(CH_MINUS);
      repeat ($urandom_range(19, 24)) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      put_num(neg, mag);
    end
  endtask

  task automatic put_well_formed();
    int unsigned terms;
    terms = $urandom_range(1, 5);
    put_spaces();
    for (int t = 0; t < terms; t++) begin
      if (t != 0) begin
        put_spaces();
        text_q.push_back(pick_op());
        put_spaces();
      end
      put_literal();
    end
    put_spaces();
  endtask

  task automatic put_random_expr();
    int unsigned r, idx;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // most negative value over minus one
      put_num(1'b1, VMIN_MAG);
      put_spaces();
      text_q.push_back(CH_SLASH);
      put_spaces();
      put_num(1'b1, 64'd1);
    end else if (r < 80) begin
      put_well_formed();
    end else if (r < 94) begin
      put_well_formed();
      idx = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0:       text_q[idx] = 8'($urandom_range(0, 255));
        1:       text_q[idx] = pick_op();
        2:       text_q.push_back(pick_op());
        default: text_q[idx] = ($urandom_range(0, 1) == 0) ? CH_SPACE
                                                           : 8'(CH_ZERO + $urandom_range(0, 9));
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) text_q.push_back(CH_SPACE);
      end else begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_results();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned n_expr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_str("1+2*3");  send_text();
    put_str("8-2-1");  send_text();
    put_str(" ");      send_text();
    put_str("7/0");    send_text();
    put_str("1+");     send_text();
    put_str("-");      send_text();
    put_str("- 1");    send_text();
    put_str("1 2");    send_text();
    put_str("*3");     send_text();
    text_q.push_back(8'h00); send_text();
    text_q.push_back(8'hFF); send_text();
    put_str("-7/2 ");  send_text();

    wait_results();
    @(posedge clk);

    sent   = 0;
    n_expr = 0;
    while (sent < CHAR_BUDGET) begin
      steady <= (sent >= 500 && sent < 850);
      put_random_expr();
      send_text();
      n_expr++;
      if (n_expr % 40 == 0) begin
        wait_results();
        @(posedge clk);
      end
    end

    wait_results();
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
